FILE: rtl/lpmd_pkg.sv
// Shared codes, constants and types for the length-prefixed message deframer.
package lpmd_pkg;

	localparam int unsigned HDR_BYTES = 8;

	localparam logic [7:0]  MAGIC_RST   = 8'd88;
	localparam logic [31:0] MAX_LEN_RST = 32'd10485760;
	localparam logic [31:0] HDR_LEN     = 32'd8;

	// Status codes on the result channel
	localparam logic [2:0] ST_HEADER    = 3'd0;
	localparam logic [2:0] ST_BODY      = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_TOO_LONG  = 3'd3;
	localparam logic [2:0] ST_TOO_SHORT = 3'd4;
	localparam logic [2:0] ST_HALTED    = 3'd5;

	// Parser phase
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_HALT   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_MAGIC   = 2'd0;
	localparam logic [1:0] REG_MAX_LEN = 2'd1;

	typedef struct packed {
		logic       err;
		logic       empty;
		logic [2:0] status;
	} hdr_chk_t;

endpackage

FILE: rtl/lpmd_hdr_check.sv
// Header check on a complete 8-byte header: magic, too long, too short, empty body.
module lpmd_hdr_check
	import lpmd_pkg::*;
(
	input  logic [63:0] hdr,
	input  logic [7:0]  magic_value,
	input  logic [31:0] max_length,
	output hdr_chk_t    chk
);

	logic [7:0]  magic;
	logic [31:0] len;

	assign magic = hdr[55:48];
	assign len   = hdr[31:0];

	always_comb begin
		chk = '{err: 1'b0, empty: 1'b0, status: ST_HEADER};
		if (magic != magic_value) begin
			chk.err    = 1'b1;
			chk.status = ST_BAD_MAGIC;
		end else if (len > max_length) begin
			chk.err    = 1'b1;
			chk.status = ST_TOO_LONG;
		end else if (len < HDR_LEN) begin
			chk.err    = 1'b1;
			chk.status = ST_TOO_SHORT;
		end else if (len == HDR_LEN) begin
			chk.empty = 1'b1;
		end
	end

endmodule

FILE: rtl/length_prefixed_message_deframer_unit.sv
// Length-prefixed message deframer: header parse, checks and body pass-through.
// Each accepted input beat loads its result beat into the output register.
// Throughput: one byte per cycle; the input is taken whenever the output register
// is empty or being drained in the same cycle.
// Reset clears phase, counters, header register and output valid; registers return
// to magic 88 and max length 10485760. An error halts parsing until reset.
module length_prefixed_message_deframer_unit
	import lpmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  body_byte,
	output logic [7:0]  version,
	output logic [15:0] service,
	output logic [31:0] msg_length,
	output logic        msg_end
);

	logic [7:0]  magic_q;
	logic [31:0] max_len_q;
	logic [1:0]  phase_q, phase_nx;
	logic [2:0]  count_q;
	logic [63:0] shift_q, shift_nx, hdr_src;
	logic [31:0] rem_q, rem_nx;
	logic        accept;
	hdr_chk_t    chk;

	logic        hdr_ok;
	logic [2:0]  st_nx;
	logic [7:0]  byte_nx;
	logic        end_nx;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  body_byte_q, version_q;
	logic [15:0] service_q;
	logic [31:0] msg_length_q;
	logic        msg_end_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign shift_nx  = {shift_q[55:0], data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MAGIC_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAGIC:   magic_q   <= cfg_data[7:0];
				REG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lpmd_hdr_check u_chk (
		.hdr         (shift_nx),
		.magic_value (magic_q),
		.max_length  (max_len_q),
		.chk         (chk)
	);

	always_comb begin
		phase_nx = phase_q;
		rem_nx   = rem_q;
		hdr_ok   = 1'b1;
		st_nx    = ST_HALTED;
		byte_nx  = 8'd0;
		end_nx   = 1'b0;
		hdr_src  = shift_q;
		unique case (phase_q)
			PH_HEADER: begin
				hdr_src = shift_nx;
				st_nx   = ST_HEADER;
				if (count_q != 3'(HDR_BYTES - 1)) begin
					hdr_ok = 1'b0;
				end else if (chk.err) begin
					phase_nx = PH_HALT;
					st_nx    = chk.status;
				end else if (chk.empty) begin
					end_nx = 1'b1;
				end else begin
					rem_nx   = shift_nx[31:0] - HDR_LEN;
					phase_nx = PH_BODY;
				end
			end
			PH_BODY: begin
				st_nx   = ST_BODY;
				byte_nx = data_byte;
				rem_nx  = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					end_nx   = 1'b1;
					phase_nx = PH_HEADER;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= 3'd0;
			shift_q <= 64'd0;
			rem_q   <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_nx;
			rem_q   <= rem_nx;
			if (phase_q == PH_HEADER) begin
				count_q <= count_q + 3'd1;
				shift_q <= shift_nx;
			end
		end
	end

	// Result register: load on accept, drop valid once drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= st_nx;
			body_byte_q  <= byte_nx;
			version_q    <= hdr_ok ? hdr_src[63:56] : 8'd0;
			service_q    <= hdr_ok ? hdr_src[47:32] : 16'd0;
			msg_length_q <= hdr_ok ? hdr_src[31:0] : 32'd0;
			msg_end_q    <= end_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign body_byte  = body_byte_q;
	assign version    = version_q;
	assign service    = service_q;
	assign msg_length = msg_length_q;
	assign msg_end    = msg_end_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("halt phase left before reset");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_BAD_MAGIC || status_q == ST_TOO_LONG ||
			status_q == ST_TOO_SHORT) |-> phase_q == PH_HALT)
		else $error("error result without halt");

	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && msg_end_q |-> status_q == ST_HEADER || status_q == ST_BODY)
		else $error("message end on error or halted result");

	a_body_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> rem_q != 32'd0)
		else $error("body phase with no bytes remaining");

endmodule
